// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the tokenizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define XST_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// next-cycle implication
`define XST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

// ----- sv/xst_pkg.sv -----
package xst_pkg;

   typedef enum logic [11:0] {
      MODE_TEXT      = 12'b0000_0000_0001,
      MODE_LT        = 12'b0000_0000_0010,
      MODE_NAME      = 12'b0000_0000_0100,
      MODE_ATTRS     = 12'b0000_0000_1000,
      MODE_SELF_END  = 12'b0000_0001_0000,
      MODE_CLOSE     = 12'b0000_0010_0000,
      MODE_COMMENT   = 12'b0000_0100_0000,
      MODE_CDATA     = 12'b0000_1000_0000,
      MODE_PI        = 12'b0001_0000_0000,
      MODE_ATTR_NAME = 12'b0010_0000_0000,
      MODE_ATTR_EQ   = 12'b0100_0000_0000,
      MODE_ATTR_VAL  = 12'b1000_0000_0000
   } mode_type;

   localparam logic [3:0] EV_TEXT       = 4'd0;
   localparam logic [3:0] EV_TEXT_END   = 4'd1;
   localparam logic [3:0] EV_TAG        = 4'd2;
   localparam logic [3:0] EV_ATTR_NAME  = 4'd3;
   localparam logic [3:0] EV_ATTR_VALUE = 4'd4;
   localparam logic [3:0] EV_ATTR_END   = 4'd5;
   localparam logic [3:0] EV_START      = 4'd6;
   localparam logic [3:0] EV_CLOSE      = 4'd7;
   localparam logic [3:0] EV_RESTART    = 4'd8;

   localparam logic [1:0] CSR_NAME_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_VALUE_LIMIT = 2'd1;
   localparam logic [1:0] CSR_TEXT_LIMIT  = 2'd2;
   localparam logic [1:0] CSR_ATTR_LIMIT  = 2'd3;

   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic [7:0] data;
      logic       is_space;
      logic       name_start;
      logic       name_char;
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic           last;
   } queue_entry_type;

   typedef struct packed {
      logic [7:0]  name_limit;
      logic [9:0]  value_limit;
      logic [11:0] text_limit;
      logic [4:0]  attr_limit;
   } limits_type;

   typedef struct packed {
      mode_type    mode;
      logic        single_quote;
      logic [7:0]  name_len;
      logic [7:0]  aname_cnt;
      logic [9:0]  value_len;
      logic [11:0] text_cnt;
      logic [4:0]  attr_num;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{mode: MODE_TEXT, default: '0};

   typedef struct packed {
      logic       valid;
      logic [3:0] kind;
      logic [7:0] char_code;
   } event_type;

   typedef struct packed {
      parse_state_type   next;
      logic [3:0]        used;
      event_type [2:0]   events;
   } act_result_type;

   function automatic event_type mk_ev(logic [3:0] kind, logic [7:0] ch);
      event_type e;
      e.valid = 1'b1;
      e.kind = kind;
      e.char_code = ch;
      return e;
   endfunction

   function automatic byte_class_type classify(logic [7:0] b);
      byte_class_type r;
      logic alpha;
      logic digit;
      alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
      digit = b >= 8'h30 && b <= 8'h39;
      r.data = b;
      r.is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
      r.name_start = alpha || b == 8'h5F || b == 8'h3A;
      r.name_char = r.name_start || digit || b == 8'h2D || b == 8'h2E;
      return r;
   endfunction

endpackage

// ----- sv/xst_front.sv -----
`include "assert_macros.svh"
module xst_front
   import xst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_data_byte,
   input  logic            req_end_of_data,
   output logic            q_valid,
   output queue_entry_type q_entry,
   input  logic            q_pop
);

   queue_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 push, pop;

   assign req_stall = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign push = req_valid && !req_stall;
   assign q_valid = count_ff != '0;
   assign pop = q_pop && q_valid;
   assign q_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // classify on the way in so the back end only looks at flags
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{cls: classify(req_data_byte), last: req_end_of_data};
      end
   end

   `XST_ASSERT(a_pop_needs_data, clock, reset, q_pop && !q_valid, 1'b0)
   `XST_ASSERT(a_count_bound, clock, reset, 1'b1, count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
   `XST_ASSERT_NEXT(a_count_tracks, clock, reset, push && !pop,
                    count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- sv/xst_decode.sv -----
module xst_decode
   import xst_pkg::*;
#(
   parameter int LOOKAHEAD_DEPTH = 8
) (
   input  parse_state_type                         st,
   input  limits_type                              lim,
   input  byte_class_type [7:0]                    win,
   input  logic [$clog2(LOOKAHEAD_DEPTH+2)-1:0]    view_len,
   output act_result_type                          res
);

   localparam int LEN_W = $clog2(LOOKAHEAD_DEPTH + 2);

   logic [7:0]  c, ch, ent_ch, quote_ch;
   logic [3:0]  ent_used;
   logic        tl_ok, nm_ok, live, ok1;
   logic [11:0] tl1;

   always_comb begin
      res = '0;
      res.next = st;
      res.used = 4'd1;
      c = win[0].data;
      tl_ok = st.text_cnt < lim.text_limit;
      nm_ok = st.name_len < lim.name_limit;
      live = st.attr_num < lim.attr_limit;
      quote_ch = st.single_quote ? CH_SQUOTE : CH_DQUOTE;
      tl1 = '0;
      ok1 = 1'b0;

      // entity after '&'; unknown ones keep the '&'
      ent_ch = CH_AMP;
      ent_used = 4'd1;
      if (view_len > LEN_W'(4) &&
          {win[1].data, win[2].data, win[3].data, win[4].data} == "amp;") begin
         ent_ch = CH_AMP;
         ent_used = 4'd5;
      end else if (view_len > LEN_W'(3) &&
                   {win[1].data, win[2].data, win[3].data} == "lt;") begin
         ent_ch = CH_LT;
         ent_used = 4'd4;
      end else if (view_len > LEN_W'(3) &&
                   {win[1].data, win[2].data, win[3].data} == "gt;") begin
         ent_ch = CH_GT;
         ent_used = 4'd4;
      end else if (view_len > LEN_W'(5) && {win[1].data, win[2].data, win[3].data,
                   win[4].data, win[5].data} == "quot;") begin
         ent_ch = CH_DQUOTE;
         ent_used = 4'd6;
      end else if (view_len > LEN_W'(5) && {win[1].data, win[2].data, win[3].data,
                   win[4].data, win[5].data} == "apos;") begin
         ent_ch = CH_SQUOTE;
         ent_used = 4'd6;
      end
      ch = (c == CH_AMP) ? ent_ch : c;

      unique case (st.mode)
         MODE_TEXT: begin
            if (c == CH_LT) begin
               if (st.text_cnt != '0) res.events[0] = mk_ev(EV_TEXT_END, 8'd0);
               res.next.text_cnt = '0;
               res.next.mode = MODE_LT;
            end else begin
               if (c == CH_AMP) res.used = ent_used;
               if (tl_ok) begin
                  res.events[0] = mk_ev(EV_TEXT, ch);
                  res.next.text_cnt = st.text_cnt + 1'b1;
               end
            end
         end
         MODE_LT: begin
            if (c == CH_SLASH) begin
               res.events[0] = mk_ev(EV_RESTART, 8'd0);
               res.next.name_len = '0;
               res.next.mode = MODE_CLOSE;
            end else if (c == CH_BANG) begin
               if (view_len > LEN_W'(3) && win[1].data == CH_DASH && win[2].data == CH_DASH) begin
                  res.next.mode = MODE_COMMENT;
                  res.used = 4'd3;
               end else if (view_len > LEN_W'(8) && {win[1].data, win[2].data, win[3].data,
                            win[4].data, win[5].data, win[6].data, win[7].data} == "[CDATA[") begin
                  res.next.mode = MODE_CDATA;
                  res.used = 4'd8;
               end else begin
                  res.next.mode = MODE_TEXT;
               end
            end else if (c == CH_QMARK) begin
               res.next.mode = MODE_PI;
            end else if (win[0].name_start) begin
               res.events[0] = mk_ev(EV_RESTART, 8'd0);
               res.next.name_len = '0;
               if (lim.name_limit != '0) begin
                  res.events[1] = mk_ev(EV_TAG, c);
                  res.next.name_len = 8'd1;
               end
               res.next.mode = MODE_NAME;
            end else begin
               // stray '<': both bytes become text
               ok1 = tl_ok;
               tl1 = st.text_cnt + 12'(ok1);
               if (ok1) res.events[0] = mk_ev(EV_TEXT, CH_LT);
               if (tl1 < lim.text_limit) begin
                  res.events[1] = mk_ev(EV_TEXT, c);
                  tl1 = tl1 + 1'b1;
               end
               res.next.text_cnt = tl1;
               res.next.mode = MODE_TEXT;
            end
         end
         MODE_NAME: begin
            if (win[0].is_space) begin
               res.next.mode = MODE_ATTRS;
            end else if (c == CH_GT || c == CH_SLASH) begin
               res.events[0] = mk_ev(EV_START, 8'd0);
               res.next.attr_num = '0;
               res.next.name_len = '0;
               if (c == CH_SLASH) begin
                  res.events[1] = mk_ev(EV_CLOSE, 8'd0);
                  res.next.mode = MODE_SELF_END;
               end else begin
                  res.next.mode = MODE_TEXT;
               end
            end else if (win[0].name_char) begin
               if (nm_ok) begin
                  res.events[0] = mk_ev(EV_TAG, c);
                  res.next.name_len = st.name_len + 1'b1;
               end
            end else begin
               res.next.mode = MODE_TEXT;
            end
         end
         MODE_ATTRS: begin
            if (c == CH_GT || c == CH_SLASH) begin
               res.events[0] = mk_ev(EV_START, 8'd0);
               res.next.attr_num = '0;
               res.next.name_len = '0;
               if (c == CH_SLASH) begin
                  res.events[1] = mk_ev(EV_CLOSE, 8'd0);
                  res.next.mode = MODE_SELF_END;
               end else begin
                  res.next.mode = MODE_TEXT;
               end
            end else if (win[0].name_start) begin
               res.next.aname_cnt = '0;
               if (live && lim.name_limit != '0) begin
                  res.events[0] = mk_ev(EV_ATTR_NAME, c);
                  res.next.aname_cnt = 8'd1;
               end
               res.next.mode = MODE_ATTR_NAME;
            end
         end
         MODE_ATTR_NAME: begin
            if (win[0].is_space || c == CH_EQ) begin
               res.next.mode = MODE_ATTR_EQ;
            end else if (win[0].name_char) begin
               if (live && st.aname_cnt < lim.name_limit) begin
                  res.events[0] = mk_ev(EV_ATTR_NAME, c);
                  res.next.aname_cnt = st.aname_cnt + 1'b1;
               end
            end else if (c == CH_GT || c == CH_SLASH) begin
               // valueless attribute closes, then the tag opens
               if (live) res.events[0] = mk_ev(EV_ATTR_END, 8'd0);
               res.next.aname_cnt = '0;
               res.next.value_len = '0;
               res.events[1] = mk_ev(EV_START, 8'd0);
               res.next.attr_num = '0;
               res.next.name_len = '0;
               if (c == CH_SLASH) begin
                  res.events[2] = mk_ev(EV_CLOSE, 8'd0);
                  res.next.mode = MODE_SELF_END;
               end else begin
                  res.next.mode = MODE_TEXT;
               end
            end
         end
         MODE_ATTR_EQ: begin
            if (c == CH_DQUOTE || c == CH_SQUOTE) begin
               res.next.single_quote = c == CH_SQUOTE;
               res.next.value_len = '0;
               res.next.mode = MODE_ATTR_VAL;
            end
         end
         MODE_ATTR_VAL: begin
            if (c == quote_ch) begin
               if (live) begin
                  res.events[0] = mk_ev(EV_ATTR_END, 8'd0);
                  res.next.attr_num = st.attr_num + 1'b1;
               end
               res.next.aname_cnt = '0;
               res.next.value_len = '0;
               res.next.mode = MODE_ATTRS;
            end else begin
               if (c == CH_AMP) res.used = ent_used;
               if (live && st.value_len < lim.value_limit) begin
                  res.events[0] = mk_ev(EV_ATTR_VALUE, ch);
                  res.next.value_len = st.value_len + 1'b1;
               end
            end
         end
         MODE_SELF_END: begin
            if (c == CH_GT) res.next.mode = MODE_TEXT;
         end
         MODE_CLOSE: begin
            if (c == CH_GT) begin
               res.events[0] = mk_ev(EV_CLOSE, 8'd0);
               res.next.name_len = '0;
               res.next.mode = MODE_TEXT;
            end else if (!win[0].is_space && nm_ok) begin
               res.events[0] = mk_ev(EV_TAG, c);
               res.next.name_len = st.name_len + 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (c == CH_DASH && view_len > LEN_W'(2) && win[1].data == CH_DASH &&
                win[2].data == CH_GT) begin
               res.next.mode = MODE_TEXT;
               res.used = 4'd3;
            end
         end
         MODE_CDATA: begin
            if (c == CH_RBRACK && view_len > LEN_W'(2) && win[1].data == CH_RBRACK &&
                win[2].data == CH_GT) begin
               if (st.text_cnt != '0) res.events[0] = mk_ev(EV_TEXT_END, 8'd0);
               res.next.text_cnt = '0;
               res.next.mode = MODE_TEXT;
               res.used = 4'd3;
            end else if (tl_ok) begin
               res.events[0] = mk_ev(EV_TEXT, c);
               res.next.text_cnt = st.text_cnt + 1'b1;
            end
         end
         MODE_PI: begin
            if (c == CH_QMARK && view_len > LEN_W'(1) && win[1].data == CH_GT) begin
               res.next.mode = MODE_TEXT;
               res.used = 4'd2;
            end
         end
         default: res.next.mode = MODE_TEXT;
      endcase
   end

endmodule

// ----- sv/xst_back.sv -----
`include "assert_macros.svh"
module xst_back
   import xst_pkg::*;
#(
   parameter int LOOKAHEAD_DEPTH = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  limits_type      lim,
   input  logic            q_valid,
   input  queue_entry_type q_entry,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [3:0]      rsp_event_kind,
   output logic [7:0]      rsp_event_char,
   output logic            rsp_last_in_run
);

   localparam int VIEW  = LOOKAHEAD_DEPTH + 1;
   localparam int LEN_W = $clog2(LOOKAHEAD_DEPTH + 2);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_ACT    = 4'b0010,
      PH_FLUSH  = 4'b0100,
      PH_FINISH = 4'b1000
   } phase_type;

   phase_type        phase_ff, phase_in;
   byte_class_type   view_ff [VIEW];
   byte_class_type   view_in [VIEW];
   logic [LEN_W-1:0] len_ff, len_in;
   logic             end_ff, end_in;
   parse_state_type  st_ff, st_in;
   logic [1:0]       sub_ff, sub_in;
   event_type        hold_ff, hold_in;
   logic             hold_v_ff, hold_v_in;
   event_type        out_ff, out_in;
   logic             out_v_ff, out_v_in;
   logic             out_last_ff, out_last_in;

   byte_class_type [7:0] win;
   act_result_type   act;
   logic [2:0]       rem;
   logic [1:0]       k;
   logic             have, last_slot, loop_cond;
   logic             out_free, emit_ok, emit, fin_push, out_load;
   logic             load, commit, clear;
   event_type        emit_ev;

   always_comb begin
      for (int i = 0; i < 8; i++) win[i] = view_ff[i];
   end

   xst_decode #(.LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)) u_decode (
      .st       (st_ff),
      .lim      (lim),
      .win      (win),
      .view_len (len_ff),
      .res      (act)
   );

   assign out_free = !out_v_ff || !rsp_stall;
   assign emit_ok = !hold_v_ff || out_free;
   assign loop_cond = (len_ff > LEN_W'(LOOKAHEAD_DEPTH)) || (end_ff && len_ff != '0);

   // next event slot of the current act still to be sent
   always_comb begin
      for (int i = 0; i < 3; i++) rem[i] = act.events[i].valid && (2'(i) >= sub_ff);
      have = rem != '0;
      if (rem[0]) begin
         k = 2'd0;
         last_slot = !rem[1] && !rem[2];
      end else if (rem[1]) begin
         k = 2'd1;
         last_slot = !rem[2];
      end else begin
         k = 2'd2;
         last_slot = 1'b1;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      end_in = end_ff;
      sub_in = sub_ff;
      q_pop = 1'b0;
      load = 1'b0;
      commit = 1'b0;
      clear = 1'b0;
      emit = 1'b0;
      emit_ev = '0;
      fin_push = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               load = 1'b1;
               end_in = q_entry.last;
               phase_in = PH_ACT;
            end
         end
         PH_ACT: begin
            if (loop_cond) begin
               if (!have) begin
                  commit = 1'b1;
               end else if (emit_ok) begin
                  emit = 1'b1;
                  emit_ev = act.events[k];
                  sub_in = k + 1'b1;
                  commit = last_slot;
               end
            end else begin
               phase_in = end_ff ? PH_FLUSH : PH_FINISH;
            end
         end
         PH_FLUSH: begin
            if (st_ff.text_cnt == '0) begin
               clear = 1'b1;
            end else if (emit_ok) begin
               emit = 1'b1;
               emit_ev = mk_ev(EV_TEXT_END, 8'd0);
               clear = 1'b1;
            end
            if (clear) phase_in = PH_FINISH;
         end
         PH_FINISH: begin
            if (!hold_v_ff) begin
               phase_in = PH_IDLE;
            end else if (out_free) begin
               fin_push = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      st_in = st_ff;
      len_in = len_ff;
      if (load) len_in = len_ff + 1'b1;
      if (commit) begin
         st_in = act.next;
         len_in = len_ff - LEN_W'(act.used);
         sub_in = '0;
      end
      if (clear) begin
         st_in = PARSE_RESET;
         len_in = '0;
         end_in = 1'b0;
      end

      for (int i = 0; i < VIEW; i++) begin
         view_in[i] = view_ff[i];
         if (load && len_ff == LEN_W'(i)) view_in[i] = q_entry.cls;
         if (commit) begin
            for (int s = 1; s <= 8; s++) begin
               if (act.used == 4'(s) && i + s < VIEW) view_in[i] = view_ff[i + s];
            end
         end
      end

      // the newest event waits in hold until we know if it ends the run
      hold_in = emit ? emit_ev : hold_ff;
      hold_v_in = emit || (hold_v_ff && !fin_push);
      out_load = (emit && hold_v_ff) || fin_push;
      out_in = out_load ? hold_ff : out_ff;
      out_last_in = out_load ? fin_push : out_last_ff;
      out_v_in = out_load || (out_v_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         len_ff <= '0;
         end_ff <= 1'b0;
         st_ff <= PARSE_RESET;
         sub_ff <= '0;
         hold_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff <= len_in;
         end_ff <= end_in;
         st_ff <= st_in;
         sub_ff <= sub_in;
         hold_v_ff <= hold_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < VIEW; i++) view_ff[i] <= view_in[i];
      hold_ff <= hold_in;
      out_ff <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_event_kind = out_ff.kind;
   assign rsp_event_char = out_ff.char_code;
   assign rsp_last_in_run = out_last_ff;

   `XST_ASSERT(a_no_overwrite, clock, reset, emit, !hold_v_ff || !out_v_ff || !rsp_stall)
   `XST_ASSERT(a_view_bound, clock, reset, 1'b1, len_ff <= LEN_W'(VIEW))
   `XST_ASSERT_NEXT(a_finish_to_idle, clock, reset, phase_ff == PH_FINISH && !hold_v_ff, phase_ff == PH_IDLE)

endmodule

// ----- sv/xml_sax_tokenizer.sv -----
// channel  | ports                              | moves
// req      | req_valid/req_stall                | one document byte plus end flag
// rsp      | rsp_valid/rsp_stall                | one event, last_in_run marks the byte's final one
// csr      | csr_write_enable/index/write_data  | limit register write
// A byte is first loaded into the window. While the window is full, the decode unit acts
// on it, and each act sends its events one at a time, waiting while the output is stalled.
// Once the window is short, the byte's final event is released from hold.
// End of data drains up to LOOKAHEAD_DEPTH+1 acts through the decode unit, then one text end if text is open.
// Reset is synchronous; it empties the queue and window and restores the limits.
// A four-entry queue keeps taking bytes while the output is stalled, until it is full.
module xml_sax_tokenizer
   import xst_pkg::*;
#(
   parameter int LOOKAHEAD_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_kind,
   output logic [7:0]  rsp_event_char,
   output logic        rsp_last_in_run,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_write_data
);

   limits_type      lim_ff, lim_in;
   logic            q_valid, q_pop;
   queue_entry_type q_entry;

   always_comb begin
      lim_in = lim_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NAME_LIMIT:  lim_in.name_limit = csr_write_data[7:0];
            CSR_VALUE_LIMIT: lim_in.value_limit = csr_write_data[9:0];
            CSR_TEXT_LIMIT:  lim_in.text_limit = csr_write_data[11:0];
            CSR_ATTR_LIMIT:  lim_in.attr_limit = csr_write_data[4:0];
            default: lim_in = lim_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= '{name_limit: 8'd255, value_limit: 10'd1023,
                     text_limit: 12'd4095, attr_limit: 5'd31};
      end else begin
         lim_ff <= lim_in;
      end
   end

   xst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_data (req_end_of_data),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop)
   );

   xst_back #(.LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .lim             (lim_ff),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_char  (rsp_event_char),
      .rsp_last_in_run (rsp_last_in_run)
   );

endmodule
